// File: hdl/vertex_transform_viewport_core_assert.svh
// Assertion macros shared by the vertex transform RTL
`ifndef VERTEX_TRANSFORM_VIEWPORT_CORE_ASSERT_SVH
`define VERTEX_TRANSFORM_VIEWPORT_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset only
`define VTV_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("vertex transform assertion failed");

// next-cycle implication, checked out of reset only
`define VTV_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("vertex transform assertion failed");

`endif

// File: hdl/vtv_pkg.sv
// Package: widths, codes, payload types and saturation helpers of the vertex transform
`timescale 1ns / 1ps
package vtv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int MUL_W     = DATA_W + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ACC_W     = 2 * DATA_W - FRAC_BITS + 2;
    localparam int SX_W      = PROD_W - FRAC_BITS;
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(NUM_W);
    localparam int MEM_DEPTH = 48;
    localparam int MEM_AW    = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int PIX_W     = 16;
    localparam int VP_W      = 14;

    localparam logic signed [DATA_W-1:0] FX_ONE = DATA_W'(64'sd1 <<< FRAC_BITS);

    localparam logic [2:0] CMD_SELECT    = 3'd0;
    localparam logic [2:0] CMD_IDENTITY  = 3'd1;
    localparam logic [2:0] CMD_TRANSLATE = 3'd2;
    localparam logic [2:0] CMD_SCALE     = 3'd3;
    localparam logic [2:0] CMD_VERTEX    = 3'd4;

    localparam logic [15:0] MODE_MODELVIEW  = 16'h1700;
    localparam logic [15:0] MODE_PROJECTION = 16'h1701;
    localparam logic [15:0] MODE_TEXTURE    = 16'h1702;

    localparam logic [1:0] MAT_MODELVIEW  = 2'd0;
    localparam logic [1:0] MAT_PROJECTION = 2'd1;
    localparam logic [1:0] MAT_TEXTURE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_VP_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VP_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VP_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VP_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_WIDTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_HEIGHT = 3'd5;

    typedef struct packed {
        logic [2:0]               command;
        logic [15:0]              mode_code;
        logic signed [DATA_W-1:0] coord_x;
        logic signed [DATA_W-1:0] coord_y;
        logic signed [DATA_W-1:0] coord_z;
    } t_vtv_in;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel_x;
        logic signed [PIX_W-1:0] pixel_y;
        logic                    on_screen;
    } t_vtv_out;

    // clamp an accumulated row sum to the data range
    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-DATA_W:0] top;
        top = v[ACC_W-1:DATA_W-1];
        if (top == '0 || top == '1) begin
            return v[DATA_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    // clamp a screen position to the pixel range
    function automatic logic signed [PIX_W-1:0] sat_pix(input logic signed [SX_W-1:0] v);
        logic [SX_W-PIX_W:0] top;
        top = v[SX_W-1:PIX_W-1];
        if (top == '0 || top == '1) begin
            return v[PIX_W-1:0];
        end else if (v[SX_W-1]) begin
            return {1'b1, {(PIX_W-1){1'b0}}};
        end else begin
            return {1'b0, {(PIX_W-1){1'b1}}};
        end
    endfunction

endpackage

// File: hdl/vertex_transform_viewport_core.sv
// Top level: matrix store, shared multiply-accumulate sequencer and viewport mapping
//
//  Channel   Direction  Handshake                  Payload
//  in        input      i_in_valid / o_in_ready    i_in_data  (t_vtv_in)
//  out       output     o_out_valid / i_out_ready  o_out_data (t_vtv_out)
//  cfg       input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
//  Select, identity and unused commands finish when they are accepted. Translate and
//  scale fetch each of the four rows in turn, and its 16 multiply-accumulates go
//  through the one shared multiplier. A vertex runs 32 multiply-accumulates, a w
//  check and, when w is not zero, two divides with a restart state between them,
//  then the mapping and output states; when w is zero the divides are skipped.
//  Reset is synchronous; the matrices read as identity until written, no sweep.
//  A waiting result sits in the output register; a following vertex holds in its
//  last state until that register is free; the input is ready only while idle.
`timescale 1ns / 1ps
`include "vertex_transform_viewport_core_assert.svh"
module vertex_transform_viewport_core
    import vtv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_vtv_in              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_vtv_out             o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // rounding bias that turns the floor shift into truncation toward zero
    localparam logic signed [PROD_W-1:0] MAP_BIAS =
        PROD_W'((66'sd1 <<< (FRAC_BITS + 1)) - 66'sd1);

    typedef enum logic [4:0] {
        S_IDLE,
        S_MX_FETCH,
        S_MX_LATCH,
        S_MX_MUL,
        S_MX_ACC,
        S_VX_FETCH,
        S_VX_MUL,
        S_VX_ACC,
        S_PDIV,
        S_DVX_W,
        S_DVY_S,
        S_DVY_W,
        S_MAPX_MUL,
        S_MAPX_BIAS,
        S_MAPX_SH,
        S_MAPY_MUL,
        S_MAPY_BIAS,
        S_MAPY_SH,
        S_OUT
    } t_state;

    t_state r_state;

    // configuration registers
    logic signed [PIX_W-1:0] r_vp_left;
    logic signed [PIX_W-1:0] r_vp_top;
    logic [VP_W-1:0]         r_vp_w;
    logic [VP_W-1:0]         r_vp_h;
    logic [VP_W-1:0]         r_scr_w;
    logic [VP_W-1:0]         r_scr_h;

    // matrix store: entries read as identity until written
    logic signed [DATA_W-1:0] r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]     r_vld;
    logic signed [DATA_W-1:0] r_q;
    logic                     r_q_vld;
    logic                     r_q_one;

    // sequencer state
    logic [1:0]               r_sel;
    logic [1:0]               r_mat;
    logic                     r_scale;
    logic                     r_pass;
    logic [1:0]               r_i;
    logic [1:0]               r_j;
    logic [1:0]               r_k;
    logic signed [DATA_W-1:0] r_row [4];
    logic signed [DATA_W-1:0] r_vec [4];
    logic signed [DATA_W-1:0] r_res [4];
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SX_W-1:0]   r_sx;
    logic signed [SX_W-1:0]   r_sy;
    logic                     r_out_valid;
    t_vtv_out                 r_out;

    logic                     in_acc;
    logic [MEM_AW-1:0]        rd_addr;
    logic                     wr_en;
    logic [MEM_AW-1:0]        wr_addr;
    logic signed [DATA_W-1:0] rd_data;
    logic signed [DATA_W-1:0] t_val;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [ACC_W-1:0]  acc_nx;
    logic signed [DATA_W-1:0] acc_sat;
    logic                     div_start;
    logic signed [DATA_W-1:0] div_num;
    logic                     div_done;
    logic signed [DATA_W-1:0] div_q;
    logic                     vis;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // unwritten entries hold the identity pattern: ones on the diagonal
    assign rd_data = r_q_vld ? r_q : (r_q_one ? FX_ONE : '0);

    always_comb begin
        unique case (r_state)
            S_MX_FETCH: rd_addr = {r_mat, r_i, r_k};
            S_VX_FETCH: rd_addr = {1'b0, r_pass, r_i, r_k};
            default:    rd_addr = '0;
        endcase
    end

    // element of the translate or scale matrix at row k, column j
    always_comb begin
        t_val = (r_k == r_j) ? FX_ONE : '0;
        if (r_scale) begin
            if (r_k == r_j && r_k != 2'd3) begin
                t_val = r_vec[r_k];
            end
        end else if (r_j == 2'd3 && r_k != 2'd3) begin
            t_val = r_vec[r_k];
        end
    end

    // operand select for the one shared multiplier
    always_comb begin
        unique case (r_state)
            S_MX_MUL: begin
                mul_a = MUL_W'(r_row[r_k]);
                mul_b = MUL_W'(t_val);
            end
            S_VX_MUL: begin
                mul_a = MUL_W'(rd_data);
                mul_b = MUL_W'(r_vec[r_k]);
            end
            S_MAPX_MUL: begin
                mul_a = MUL_W'(r_res[0]) + MUL_W'(FX_ONE);
                mul_b = MUL_W'(r_vp_w);
            end
            S_MAPY_MUL: begin
                mul_a = MUL_W'(FX_ONE) - MUL_W'(r_res[1]);
                mul_b = MUL_W'(r_vp_h);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign acc_nx  = r_acc + ACC_W'(r_prod >>> FRAC_BITS);
    assign acc_sat = sat_data(acc_nx);

    // write each finished element of the updated row straight back
    assign wr_en   = (r_state == S_MX_ACC) && (r_k == 2'd3);
    assign wr_addr = {r_mat, r_i, r_j};

    assign div_start = ((r_state == S_PDIV) && (r_res[3] != '0)) || (r_state == S_DVY_S);
    assign div_num   = (r_state == S_DVY_S) ? r_res[1] : r_res[0];

    assign vis = !r_sx[SX_W-1] && (r_sx < SX_W'(r_scr_w)) &&
                 !r_sy[SX_W-1] && (r_sy < SX_W'(r_scr_h));

    vtv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_res[3]),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // matrix memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= acc_sat;
        end
        r_q <= r_mem[rd_addr];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp_left <= '0;
            r_vp_top  <= '0;
            r_vp_w    <= VP_W'(640);
            r_vp_h    <= VP_W'(480);
            r_scr_w   <= VP_W'(640);
            r_scr_h   <= VP_W'(480);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VP_LEFT:    r_vp_left <= i_cfg_data;
                CFG_VP_TOP:     r_vp_top  <= i_cfg_data;
                CFG_VP_WIDTH:   r_vp_w    <= i_cfg_data[VP_W-1:0];
                CFG_VP_HEIGHT:  r_vp_h    <= i_cfg_data[VP_W-1:0];
                CFG_SCR_WIDTH:  r_scr_w   <= i_cfg_data[VP_W-1:0];
                CFG_SCR_HEIGHT: r_scr_h   <= i_cfg_data[VP_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer, valid bits and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= MAT_MODELVIEW;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
            r_pass      <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_acc       <= '0;
        end else begin
            r_q_vld <= r_vld[rd_addr];
            r_q_one <= (rd_addr[3:0] == 4'd0) || (rd_addr[3:0] == 4'd5) ||
                       (rd_addr[3:0] == 4'd10) || (rd_addr[3:0] == 4'd15);
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            // drop the taken result unless a new one loads in the same cycle
            if (r_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_mat   <= r_sel;
                        r_scale <= (i_in_data.command == CMD_SCALE);
                        r_vec[0] <= i_in_data.coord_x;
                        r_vec[1] <= i_in_data.coord_y;
                        r_vec[2] <= i_in_data.coord_z;
                        r_vec[3] <= FX_ONE;
                        r_i    <= '0;
                        r_j    <= '0;
                        r_k    <= '0;
                        r_acc  <= '0;
                        r_pass <= 1'b0;
                        unique case (i_in_data.command)
                            CMD_SELECT: begin
                                priority if (i_in_data.mode_code == MODE_PROJECTION) begin
                                    r_sel <= MAT_PROJECTION;
                                end else if (i_in_data.mode_code == MODE_TEXTURE) begin
                                    r_sel <= MAT_TEXTURE;
                                end else begin
                                    r_sel <= MAT_MODELVIEW;
                                end
                            end
                            CMD_IDENTITY: begin
                                // drop the valid bits: the entries fall back to identity
                                for (int e = 0; e < MEM_DEPTH; e++) begin
                                    if (2'(e / 16) == r_sel) begin
                                        r_vld[e] <= 1'b0;
                                    end
                                end
                            end
                            CMD_TRANSLATE, CMD_SCALE: r_state <= S_MX_FETCH;
                            CMD_VERTEX:               r_state <= S_VX_FETCH;
                            default: ;
                        endcase
                    end
                end

                // cache one row of the current matrix
                S_MX_FETCH: r_state <= S_MX_LATCH;
                S_MX_LATCH: begin
                    r_row[r_k] <= rd_data;
                    r_k        <= r_k + 2'd1;
                    r_state    <= (r_k == 2'd3) ? S_MX_MUL : S_MX_FETCH;
                end
                S_MX_MUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_MX_ACC;
                end
                S_MX_ACC: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_acc <= '0;
                        r_j   <= r_j + 2'd1;
                        if (r_j == 2'd3) begin
                            r_i     <= r_i + 2'd1;
                            r_state <= (r_i == 2'd3) ? S_IDLE : S_MX_FETCH;
                        end else begin
                            r_state <= S_MX_MUL;
                        end
                    end else begin
                        r_acc   <= acc_nx;
                        r_state <= S_MX_MUL;
                    end
                end

                // modelview pass, then projection pass on its result
                S_VX_FETCH: r_state <= S_VX_MUL;
                S_VX_MUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_VX_ACC;
                end
                S_VX_ACC: begin
                    r_k     <= r_k + 2'd1;
                    r_state <= S_VX_FETCH;
                    if (r_k == 2'd3) begin
                        r_acc      <= '0;
                        r_res[r_i] <= acc_sat;
                        r_i        <= r_i + 2'd1;
                        if (r_i == 2'd3) begin
                            if (!r_pass) begin
                                r_pass   <= 1'b1;
                                r_vec[0] <= r_res[0];
                                r_vec[1] <= r_res[1];
                                r_vec[2] <= r_res[2];
                                r_vec[3] <= acc_sat;
                            end else begin
                                r_state <= S_PDIV;
                            end
                        end
                    end else begin
                        r_acc <= acc_nx;
                    end
                end

                // skip the divide when w is zero
                S_PDIV: r_state <= (r_res[3] != '0) ? S_DVX_W : S_MAPX_MUL;
                S_DVX_W: begin
                    if (div_done) begin
                        r_res[0] <= div_q;
                        r_state  <= S_DVY_S;
                    end
                end
                S_DVY_S: r_state <= S_DVY_W;
                S_DVY_W: begin
                    if (div_done) begin
                        r_res[1] <= div_q;
                        r_state  <= S_MAPX_MUL;
                    end
                end

                // viewport mapping, x then y
                S_MAPX_MUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_MAPX_BIAS;
                end
                S_MAPX_BIAS: begin
                    if (r_prod[PROD_W-1]) begin
                        r_prod <= r_prod + MAP_BIAS;
                    end
                    r_state <= S_MAPX_SH;
                end
                S_MAPX_SH: begin
                    r_sx    <= SX_W'(r_prod >>> (FRAC_BITS + 1)) + SX_W'(r_vp_left);
                    r_state <= S_MAPY_MUL;
                end
                S_MAPY_MUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_MAPY_BIAS;
                end
                S_MAPY_BIAS: begin
                    if (r_prod[PROD_W-1]) begin
                        r_prod <= r_prod + MAP_BIAS;
                    end
                    r_state <= S_MAPY_SH;
                end
                S_MAPY_SH: begin
                    r_sy    <= SX_W'(r_prod >>> (FRAC_BITS + 1)) + SX_W'(r_vp_top);
                    r_state <= S_OUT;
                end

                // hold until the output register is free
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.pixel_x   <= sat_pix(r_sx);
                        r_out.pixel_y   <= sat_pix(r_sy);
                        r_out.on_screen <= vis;
                        r_out_valid     <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    `VTV_ASSERT_IMP(a_div_done_wait, i_clk, i_rst_n, div_done, (r_state == S_DVX_W) || (r_state == S_DVY_W))
    `VTV_ASSERT_NXT(a_vx_start, i_clk, i_rst_n, in_acc && (i_in_data.command == CMD_VERTEX), (r_state == S_VX_FETCH) && (r_acc == '0) && !r_pass && (r_i == 2'd0) && (r_k == 2'd0))
    `VTV_ASSERT_IMP(a_out_load, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_OUT))

endmodule

// File: hdl/vtv_div.sv
// Radix-2 restoring divider for the perspective divide, one quotient bit per cycle
`timescale 1ns / 1ps
module vtv_div
    import vtv_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DATA_W-1:0] i_num,
    input  logic signed [DATA_W-1:0] i_den,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_den;
    logic [NUM_W-1:0]     r_num;

    logic [DATA_W-1:0] num_mag;
    logic [DATA_W-1:0] den_mag;
    logic [DATA_W:0]   rem_sh;
    logic              q_bit;
    logic [DATA_W-1:0] rem_nx;

    assign num_mag = i_num[DATA_W-1] ? DATA_W'(-i_num) : DATA_W'(i_num);
    assign den_mag = i_den[DATA_W-1] ? DATA_W'(-i_den) : DATA_W'(i_den);
    assign rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, r_den});
    assign rem_nx  = q_bit ? DATA_W'(rem_sh - {1'b0, r_den}) : rem_sh[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= den_mag;
                r_neg  <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
                r_num  <= NUM_W'(num_mag) << FRAC_BITS;
            end else if (r_busy) begin
                r_rem <= rem_nx;
                r_num <= {r_num[NUM_W-2:0], q_bit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // apply the sign and saturate the magnitude quotient
    always_comb begin
        if (!r_neg) begin
            o_quot = (|r_num[NUM_W-1:DATA_W-1]) ? {1'b0, {(DATA_W-1){1'b1}}}
                                                 : r_num[DATA_W-1:0];
        end else if ((|r_num[NUM_W-1:DATA_W]) ||
                     (r_num[DATA_W-1] && (|r_num[DATA_W-2:0]))) begin
            o_quot = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            o_quot = -r_num[DATA_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

// File: tb/sv/vertex_transform_viewport_core_tb.sv
// Testbench: predicts and checks every pixel result of the vertex transform core
`timescale 1ns / 1ps
module vertex_transform_viewport_core_tb;
    import vtv_pkg::*;

    typedef logic signed [DATA_W-1:0] q_t;
    typedef q_t vec4_t [4];

    localparam longint ONE_L    = longint'(1) << FRAC_BITS;
    localparam longint LIMIT    = 3000000;
    localparam int     SETTLE   = 400;   // longer than a matrix update or a vertex

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_vtv_in              i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_vtv_out             o_out_data;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    vertex_transform_viewport_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state: matrices, selected matrix and viewport registers
    q_t          mat_mem [MEM_DEPTH];
    logic [1:0]  cur_mat;
    logic [15:0] vp_left, vp_top;
    logic [13:0] vp_width, vp_height, scr_width, scr_height;

    t_vtv_out pixel_q [$];

    int     send_idle_pct;
    int     stall_pct;
    int     hold_left;
    int     fail_count;
    int     item_count;
    int     pixel_count;
    int     cfg_count;
    longint cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hold the run to a generous cycle budget
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pixel_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: stall at the phase rate, or hold off for a counted stretch
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic q_t clamp_q(input longint v);
        if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
        if (v < -longint'(32'sh7fffffff) - 1) return 32'sh80000000;
        return q_t'(v);
    endfunction

    // product shifted down with rounding toward minus infinity
    function automatic longint fx_mul(input q_t a, input q_t b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> FRAC_BITS;
    endfunction

    function automatic vec4_t row_transform(input int base, input vec4_t v);
        vec4_t  r;
        longint acc;
        for (int i = 0; i < 4; i++) begin
            acc = 0;
            for (int k = 0; k < 4; k++) acc += fx_mul(mat_mem[base + i*4 + k], v[k]);
            r[i] = clamp_q(acc);
        end
        return r;
    endfunction

    task automatic load_identity_at(input int base);
        for (int i = 0; i < 16; i++) mat_mem[base + i] = (i % 5 == 0) ? FX_ONE : '0;
    endtask

    // right-multiply the matrix at base by a translation or scale
    task automatic right_multiply_at(input int base, input q_t op [16]);
        q_t     tmp [16];
        longint acc;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                acc = 0;
                for (int k = 0; k < 4; k++)
                    acc += fx_mul(mat_mem[base + i*4 + k], op[k*4 + j]);
                tmp[i*4 + j] = clamp_q(acc);
            end
        end
        for (int i = 0; i < 16; i++) mat_mem[base + i] = tmp[i];
    endtask

    function automatic logic signed [PIX_W-1:0] clamp_pix(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[PIX_W-1:0];
    endfunction

    // advance the predicted state by one accepted item, queue any pixel result
    task automatic predict_command(input t_vtv_in it);
        int       base;
        q_t       op [16];
        vec4_t    v, r, f;
        longint   fx, fy, sx, sy;
        t_vtv_out res;
        base = (cur_mat < 2'd3) ? int'(cur_mat) * 16 : 0;
        case (it.command)
            CMD_SELECT: begin
                if (it.mode_code == MODE_PROJECTION)   cur_mat = MAT_PROJECTION;
                else if (it.mode_code == MODE_TEXTURE) cur_mat = MAT_TEXTURE;
                else                                   cur_mat = MAT_MODELVIEW;
            end
            CMD_IDENTITY: load_identity_at(base);
            CMD_TRANSLATE, CMD_SCALE: begin
                for (int i = 0; i < 16; i++) op[i] = (i % 5 == 0) ? FX_ONE : '0;
                if (it.command == CMD_TRANSLATE) begin
                    op[3] = it.coord_x; op[7] = it.coord_y; op[11] = it.coord_z;
                end else begin
                    op[0] = it.coord_x; op[5] = it.coord_y; op[10] = it.coord_z;
                end
                right_multiply_at(base, op);
            end
            CMD_VERTEX: begin
                v[0] = it.coord_x; v[1] = it.coord_y; v[2] = it.coord_z; v[3] = FX_ONE;
                r  = row_transform(0, v);
                f  = row_transform(16, r);
                fx = f[0];
                fy = f[1];
                if (f[3] != 0) begin
                    fx = clamp_q((longint'(f[0]) * ONE_L) / longint'(f[3]));
                    fy = clamp_q((longint'(f[1]) * ONE_L) / longint'(f[3]));
                end
                sx = ((fx + ONE_L) * longint'(vp_width)) / (2 * ONE_L)
                     + longint'($signed(vp_left));
                sy = ((ONE_L - fy) * longint'(vp_height)) / (2 * ONE_L)
                     + longint'($signed(vp_top));
                res.pixel_x   = clamp_pix(sx);
                res.pixel_y   = clamp_pix(sy);
                res.on_screen = (sx >= 0) && (sx < longint'(scr_width)) &&
                                (sy >= 0) && (sy < longint'(scr_height));
                pixel_q.push_back(res);
            end
            default: ;  // unused commands leave the state alone
        endcase
    endtask

    // ---------------------------------------------------------------- checker

    always @(posedge i_clk) begin
        t_vtv_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            pixel_count++;
            if (pixel_q.size() == 0) begin
                $error("result with no expectation waiting: x=%0d y=%0d on=%0b",
                       o_out_data.pixel_x, o_out_data.pixel_y, o_out_data.on_screen);
                fail_count++;
            end else begin
                want = pixel_q.pop_front();
                if (o_out_data.pixel_x !== want.pixel_x) begin
                    $error("pixel_x: expected %0d, got %0d", want.pixel_x,
                           o_out_data.pixel_x);
                    fail_count++;
                end
                if (o_out_data.pixel_y !== want.pixel_y) begin
                    $error("pixel_y: expected %0d, got %0d", want.pixel_y,
                           o_out_data.pixel_y);
                    fail_count++;
                end
                if (o_out_data.on_screen !== want.on_screen) begin
                    $error("on_screen: expected %0b, got %0b", want.on_screen,
                           o_out_data.on_screen);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- drivers
    // Every driver task is entered and left just after a falling edge.

    task automatic send_item(input t_vtv_in it);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = it;
        do @(posedge i_clk); while (!o_in_ready);
        predict_command(it);
        item_count++;
        @(negedge i_clk);
    endtask

    task automatic send_cmd(input logic [2:0] cmd, input logic [15:0] mode,
                            input q_t x, input q_t y, input q_t z);
        t_vtv_in it;
        it.command = cmd; it.mode_code = mode;
        it.coord_x = x; it.coord_y = y; it.coord_z = z;
        send_item(it);
    endtask

    // drop valid and wait until every result is in and the core has settled
    task automatic drain();
        i_in_valid = 1'b0;
        while (pixel_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        cfg_count++;
        case (idx)
            CFG_VP_LEFT:    vp_left    = val;
            CFG_VP_TOP:     vp_top     = val;
            CFG_VP_WIDTH:   vp_width   = val[13:0];
            CFG_VP_HEIGHT:  vp_height  = val[13:0];
            CFG_SCR_WIDTH:  scr_width  = val[13:0];
            CFG_SCR_HEIGHT: scr_height = val[13:0];
            default: ;  // indexes past the last register are ignored
        endcase
    endtask

    task automatic write_viewport(input int left, input int top, input int vw, input int vh,
                                  input int sw, input int sh);
        write_reg(CFG_VP_LEFT, 16'(left));
        write_reg(CFG_VP_TOP, 16'(top));
        write_reg(CFG_VP_WIDTH, 16'(vw));
        write_reg(CFG_VP_HEIGHT, 16'(vh));
        write_reg(CFG_SCR_WIDTH, 16'(sw));
        write_reg(CFG_SCR_HEIGHT, 16'(sh));
    endtask

    // ---------------------------------------------------------------- random items

    function automatic q_t rand_coord();
        case ($urandom_range(3))
            0:       return q_t'($urandom);
            1:       return q_t'($urandom_range(0, 524288)) - q_t'(262144);
            2:       return q_t'($urandom_range(0, 2 * 65536)) - FX_ONE;
            default: begin
                case ($urandom_range(3))
                    0:       return 32'sh7fffffff;
                    1:       return 32'sh80000000;
                    2:       return '0;
                    default: return FX_ONE;
                endcase
            end
        endcase
    endfunction

    // small factor near one so that chains of scales do not saturate at once
    function automatic q_t rand_factor();
        if ($urandom_range(9) == 0) return rand_coord();
        return q_t'($urandom_range(32768, 131072)) * (($urandom_range(1) != 0) ? 1 : -1);
    endfunction

    function automatic t_vtv_in rand_item();
        t_vtv_in it;
        int      pick;
        pick         = $urandom_range(99);
        it.mode_code = 16'($urandom);
        it.coord_x   = rand_coord();
        it.coord_y   = rand_coord();
        it.coord_z   = rand_coord();
        if (pick < 50) begin
            it.command = CMD_VERTEX;
        end else if (pick < 64) begin
            it.command = CMD_SELECT;
            case ($urandom_range(4))
                0: it.mode_code = MODE_MODELVIEW;
                1, 2: it.mode_code = MODE_PROJECTION;
                3: it.mode_code = MODE_TEXTURE;
                default: ;
            endcase
        end else if (pick < 72) begin
            it.command = CMD_IDENTITY;
        end else if (pick < 84) begin
            it.command = CMD_TRANSLATE;
        end else if (pick < 97) begin
            it.command = CMD_SCALE;
            it.coord_x = rand_factor();
            it.coord_y = rand_factor();
            it.coord_z = rand_factor();
        end else begin
            it.command = 3'($urandom_range(5, 7));
        end
        return it;
    endfunction

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) send_item(rand_item());
    endtask

    // ---------------------------------------------------------------- tests

    // extremes of the fields, every command and each special case
    task automatic test_directed();
        send_cmd(CMD_VERTEX, 16'h0, '0, '0, '0);
        send_cmd(CMD_VERTEX, 16'hffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_cmd(CMD_VERTEX, 16'h0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_cmd(CMD_VERTEX, 16'h0, FX_ONE, -FX_ONE, '0);
        send_cmd(CMD_VERTEX, 16'h0, -FX_ONE, FX_ONE, FX_ONE);
        send_cmd(CMD_TRANSLATE, 16'h0, FX_ONE >>> 1, -(FX_ONE >>> 2), FX_ONE);
        send_cmd(CMD_VERTEX, 16'h0, '0, '0, '0);
        send_cmd(CMD_SCALE, 16'h0, 32'sh7fffffff, 32'sh80000000, '0);
        send_cmd(CMD_VERTEX, 16'h0, FX_ONE, FX_ONE, FX_ONE);
        send_cmd(CMD_IDENTITY, 16'h0, '0, '0, '0);
        send_cmd(CMD_SELECT, MODE_PROJECTION, '0, '0, '0);
        send_cmd(CMD_SCALE, 16'h0, FX_ONE <<< 1, FX_ONE >>> 1, FX_ONE);
        send_cmd(CMD_VERTEX, 16'h0, FX_ONE >>> 1, FX_ONE >>> 1, '0);
        send_cmd(CMD_SELECT, MODE_TEXTURE, '0, '0, '0);
        send_cmd(CMD_TRANSLATE, 16'h0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_cmd(CMD_VERTEX, 16'h0, '0, '0, '0);   // texture plays no part
        send_cmd(CMD_SELECT, 16'h1703, '0, '0, '0); // unknown mode falls to modelview
        send_cmd(CMD_TRANSLATE, 16'h0, -FX_ONE, '0, '0);
        send_cmd(CMD_VERTEX, 16'h0, '0, '0, '0);
        send_cmd(3'd5, 16'hffff, 32'sh7fffffff, '0, '0);
        send_cmd(3'd6, 16'h0, '0, 32'sh80000000, '0);
        send_cmd(3'd7, 16'h1701, '0, '0, 32'sh7fffffff);
        send_cmd(CMD_VERTEX, 16'h0, '0, '0, '0);
        send_cmd(CMD_IDENTITY, 16'h0, '0, '0, '0);
        drain();
    endtask

    // extreme register settings, including out-of-range and ignored indexes
    task automatic test_config_extremes();
        write_viewport(-32768, 32767, 0, 16383, 0, 1);
        write_reg(3'd6, 16'hffff);
        write_reg(3'd7, 16'h1234);
        for (int n = 0; n < 12; n++) send_cmd(CMD_VERTEX, 16'h0, rand_coord(),
                                               rand_coord(), rand_coord());
        drain();
        write_viewport(32767, -32768, 16383, 0, 16383, 16383);
        for (int n = 0; n < 12; n++) send_cmd(CMD_VERTEX, 16'h0, rand_coord(),
                                               rand_coord(), rand_coord());
        drain();
        write_viewport(0, 0, 8192, 8192, 8192, 8192);
        for (int n = 0; n < 12; n++) send_cmd(CMD_VERTEX, 16'h0, rand_coord(),
                                               rand_coord(), rand_coord());
        drain();
    endtask

    // random items under one idling pattern, then a fresh viewport
    task automatic test_random_phase(input int idle_pct, input int stall, input int count);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        run_random(count);
        drain();
        write_viewport($urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100,
                       $urandom_range(1, 2048), $urandom_range(1, 2048),
                       $urandom_range(1, 2048), $urandom_range(1, 2048));
    endtask

    // hold the receiver off while items keep coming, then pause the sender
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 1500;
        for (int n = 0; n < 12; n++) send_cmd(CMD_VERTEX, 16'h0, rand_coord(),
                                               rand_coord(), rand_coord());
        drain();
        run_random(30);
        drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_ready   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 0;
        fail_count    = 0;
        item_count    = 0;
        pixel_count   = 0;
        cfg_count     = 0;
        cycle_count   = 0;
        load_identity_at(0);
        load_identity_at(16);
        load_identity_at(32);
        cur_mat    = MAT_MODELVIEW;
        vp_left    = '0;
        vp_top     = '0;
        vp_width   = 14'd640;
        vp_height  = 14'd480;
        scr_width  = 14'd640;
        scr_height = 14'd480;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random_phase(0, 0, 200);
        test_random_phase(50, 0, 200);
        test_random_phase(0, 50, 200);
        test_random_phase(6, 6, 200);
        drain();

        $display("ran %0d items and %0d register writes; checked %0d pixel results",
                 item_count, cfg_count, pixel_count);
        $display("phases: directed, register extremes, long hold-off, four idling mixes");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
